// ===== rtl/bmt_pkg.sv =====
package bmt_pkg;

	// Fixed field widths of the sample and result items
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned COUNT_OUT_W = 8;
	localparam int unsigned USED_OUT_W  = 4;

	// Default sizing of the value table
	localparam int unsigned ENTRIES_DEF    = 10;
	localparam int unsigned COUNT_BITS_DEF = 8;

	// One sample item
	typedef struct packed {
		logic [WORD_W-1:0] sample_value;
		logic              start_set;
	} sample_t;

	// One result item
	typedef struct packed {
		logic                   has_mode;
		logic [WORD_W-1:0]      mode_value;
		logic [COUNT_OUT_W-1:0] mode_count;
		logic [USED_OUT_W-1:0]  distinct_used;
	} result_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic cap;    // take a sample transfer, clear the table on start_set
		logic match;  // register the entry compare
		logic upd;    // commit table update and load the result register
	} ctrl_cmd_t;

endpackage

// ===== rtl/bmt_ctrl.sv =====
module bmt_ctrl import bmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_stall,
	output logic       result_valid,
	input  logic       result_stall,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_MATCH  = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;
	logic   out_free;

	// Result register can take a new result when empty or draining now
	assign out_free = !result_valid_q || !result_stall;

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state; hold the result valid until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.upd) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/bmt_datapath.sv =====
module bmt_datapath import bmt_pkg::*; #(
	parameter int unsigned ENTRIES    = ENTRIES_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	input  sample_t           sample_item,
	input  logic              cfg_valid,
	input  logic [WORD_W-1:0] cfg_data,
	output result_t           result_item
);

	localparam int unsigned UW  = $clog2(ENTRIES + 1);
	localparam int unsigned MCW = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;
	localparam int unsigned UXW = (UW > USED_OUT_W) ? UW : USED_OUT_W;

	// Table storage, written only at or below the fill count
	logic [WORD_W-1:0]     entry_value_q [ENTRIES];
	logic [COUNT_BITS-1:0] entry_count_q [ENTRIES];
	logic [COUNT_BITS-1:0] count_inc [ENTRIES];
	logic [ENTRIES-1:0]    hit_now;

	logic [UW-1:0]         used_q;
	logic                  mode_valid_q;
	logic [WORD_W-1:0]     mode_value_q;
	logic [COUNT_BITS-1:0] mode_count_q;
	logic [WORD_W-1:0]     no_data_q;

	sample_t               sample_s1;
	logic [ENTRIES-1:0]    hit_s2;
	logic                  skip_s2;

	logic                  hit_any;
	logic                  full;
	logic [COUNT_BITS-1:0] hit_count;
	logic [UW-1:0]         used_d;
	logic                  mode_valid_d;
	logic [WORD_W-1:0]     mode_value_d;
	logic [COUNT_BITS-1:0] mode_count_d;
	logic [MCW-1:0]        mode_count_ext;
	logic [UXW-1:0]        used_ext;
	result_t               result_d;
	result_t               result_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_data_q <= '0;
		end else if (cfg_valid) begin
			no_data_q <= cfg_data;
		end
	end

	// Capture the sample
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			sample_s1 <= sample_item;
		end
	end

	// Per-entry compare and saturating increment
	for (genvar i = 0; i < ENTRIES; i++) begin : g_lane
		assign hit_now[i] = (UW'(i) < used_q) &&
			(entry_value_q[i] == sample_s1.sample_value);
		assign count_inc[i] = (entry_count_q[i] == '1) ? entry_count_q[i] :
			entry_count_q[i] + COUNT_BITS'(1);

		// Bump a matching entry or fill the next free one
		always_ff @(posedge clk) begin
			if (cmd.upd && !skip_s2) begin
				if (hit_s2[i]) begin
					entry_count_q[i] <= count_inc[i];
				end else if (!hit_any && (used_q == UW'(i))) begin
					entry_value_q[i] <= sample_s1.sample_value;
					entry_count_q[i] <= COUNT_BITS'(1);
				end
			end
		end
	end

	// Register the compare result
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_s2  <= hit_now;
			skip_s2 <= (sample_s1.sample_value == no_data_q);
		end
	end

	assign hit_any = |hit_s2;
	assign full    = (used_q == UW'(ENTRIES));

	// Select the new count of the matching entry
	always_comb begin
		hit_count = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			hit_count = hit_count | (hit_s2[k] ? count_inc[k] : '0);
		end
	end

	// Next mode and fill count
	always_comb begin
		used_d       = used_q;
		mode_valid_d = mode_valid_q;
		mode_value_d = mode_value_q;
		mode_count_d = mode_count_q;
		if (!skip_s2) begin
			if (hit_any) begin
				if (!mode_valid_q || (hit_count > mode_count_q)) begin
					mode_valid_d = 1'b1;
					mode_value_d = sample_s1.sample_value;
					mode_count_d = hit_count;
				end
			end else if (!full) begin
				used_d = used_q + UW'(1);
				if (!mode_valid_q) begin
					mode_valid_d = 1'b1;
					mode_value_d = sample_s1.sample_value;
					mode_count_d = COUNT_BITS'(1);
				end
			end
		end
	end

	// Format the result item
	assign mode_count_ext = MCW'(mode_count_d);
	assign used_ext       = UXW'(used_d);

	always_comb begin
		result_d.has_mode      = mode_valid_d;
		result_d.mode_value    = mode_valid_d ? mode_value_d : no_data_q;
		result_d.mode_count    = mode_valid_d ? mode_count_ext[COUNT_OUT_W-1:0] : '0;
		result_d.distinct_used = used_ext[USED_OUT_W-1:0];
	end

	// Table control state: clear on start_set, commit on update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			mode_valid_q <= 1'b0;
		end else if (cmd.cap && sample_item.start_set) begin
			used_q       <= '0;
			mode_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			used_q       <= used_d;
			mode_valid_q <= mode_valid_d;
		end
	end

	// Mode copy and result register
	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			mode_value_q <= mode_value_d;
			mode_count_q <= mode_count_d;
			result_q     <= result_d;
		end
	end

	assign result_item = result_q;

endmodule

// ===== rtl/bounded_mode_tracker.sv =====
// Running mode of a short run of 32-bit sample words. Each sample transfer
// yields one result transfer carrying the most frequent value seen since the
// last start_set, its saturating count and the number of table entries in use.
// Samples equal to the no-data word (cfg port, reset 0) are not counted. Only
// one sample is in flight: the sample is captured on the transfer, compared
// in parallel against all entries and then used for the table update, which
// loads the result register; the block takes no new sample until it is
// through with the last one. The result register lets the next sample
// be taken while a result still waits. Configuration writes are always ready
// and must be done while no sample is in flight.
module bounded_mode_tracker import bmt_pkg::*; #(
	parameter int unsigned ENTRIES    = ENTRIES_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample_item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WORD_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	bmt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	bmt_datapath #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample_item (sample_item),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.result_item (result_item)
	);

endmodule

// ===== rtl/bmt_checker.sv =====
module bmt_checker import bmt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input logic              result_valid,
	input logic              result_stall,
	input result_t           result_item
);

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_item))
		else $error("stalled result changed");

	// An empty set reports no count and no entries
	a_no_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.has_mode |->
			(result_item.mode_count == '0) && (result_item.distinct_used == '0))
		else $error("count or entries reported without a mode");

	// A mode implies a counted entry
	a_mode_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.has_mode |-> (result_item.mode_count != '0))
		else $error("mode reported with zero count");

	// One sample in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("second sample taken while one is in flight");

endmodule

bind bounded_mode_tracker bmt_checker u_bmt_checker (.*);
